/* sv/dasp_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package dasp_pkg;

	// request kinds carried in the low bits of tuser
	typedef enum logic [2:0] {
		MODE_TICK      = 3'd0,
		MODE_MOVE      = 3'd1,
		MODE_STOP_AXIS = 3'd2,
		MODE_STOP_ALL  = 3'd3,
		MODE_HOLD      = 3'd4,
		MODE_INIT      = 3'd5
	} mode_t;

	// configuration register indexes
	typedef enum logic [1:0] {
		CFG_STEP_FREQ = 2'd0,
		CFG_X_RUN     = 2'd1,
		CFG_Y_RUN     = 2'd2,
		CFG_HOLD_PCT  = 2'd3
	} cfg_idx_t;

	localparam int DIV_W    = 20;   // step divider width
	localparam int CUR_W    = 16;   // current compare width
	localparam int PCT_W    = 8;    // hold percent width
	localparam int FREQ_W   = 16;   // step rate register width
	localparam int CNT_W    = 32;   // toggle counter width
	localparam int REM_W    = 31;   // reported remaining count width

	// floor(p / 100) == (p * HOLD_RECIP) >> HOLD_SHIFT for any 24 bit p
	localparam int                PROD_W     = CUR_W + PCT_W;
	localparam int                RECIP_W    = 25;
	localparam logic [RECIP_W-1:0] HOLD_RECIP = 25'd21474837;
	localparam int                HOLD_SHIFT = 31;

	// fields ordered so that x_step_level lands in bit 0
	typedef struct packed {
		logic             y_idle;
		logic             x_idle;
		logic [CUR_W-1:0] y_current_ref;
		logic [CUR_W-1:0] x_current_ref;
		logic [REM_W-1:0] y_remaining;
		logic [REM_W-1:0] x_remaining;
		logic             timer_active;
		logic             y_direction;
		logic             x_direction;
		logic             y_step_level;
		logic             x_step_level;
	} res_t;

	localparam int RES_W   = $bits(res_t);
	localparam int M_TDATA_W = ((RES_W + 7) / 8) * 8;

endpackage

`default_nettype wire

/* sv/dual_axis_step_pulse_generator.sv */
`timescale 1ns / 1ps
`default_nettype none

// channel   | dir | tdata                         | tuser
// ----------+-----+-------------------------------+----------------------
// s_axis    | in  | move_len[31:0]                | mode[2:0], axis[4:3]
// m_axis    | out | result word, see port comment | -
// cfg       | in  | write enable, index, data     | -
//
// one request word per cycle while tready is high; each gives one registered result word
// the reload divider runs one quotient bit per cycle; after reset and after every
// config write tready stays low until the divider has restarted and finished its pass
// a two-entry output stage (register plus skid) keeps the input open for one
// more word while a result waits on m_axis_tready
// arst_n clears all axis state and valid flags and restarts the divider; config registers take their defaults

module dual_axis_step_pulse_generator #(
	parameter int STEP_MIN_HZ  = 100,
	parameter int STEP_MAX_HZ  = 20000,
	parameter int BASE_TICK_HZ = 1000000
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,

	input  wire logic                           s_axis_tvalid,
	output logic                                s_axis_tready,
	input  wire logic [31:0]                    s_axis_tdata,  // move_len
	input  wire logic [4:0]                     s_axis_tuser,  // mode[2:0], axis[4:3]

	output logic                                m_axis_tvalid,
	input  wire logic                           m_axis_tready,
	// x_step_level, y_step_level, x_direction, y_direction, timer_active,
	// x_remaining[35:5], y_remaining[66:36], x_current_ref[82:67],
	// y_current_ref[98:83], x_idle[99], y_idle[100], zero pad
	output logic [dasp_pkg::M_TDATA_W-1:0]      m_axis_tdata,

	input  wire logic                           cfg_wr_en,
	input  wire logic [1:0]                     cfg_index,
	input  wire logic [dasp_pkg::FREQ_W-1:0]    cfg_wr_data
);

	localparam int DIV_W  = dasp_pkg::DIV_W;
	localparam int CUR_W  = dasp_pkg::CUR_W;
	localparam int PCT_W  = dasp_pkg::PCT_W;
	localparam int FREQ_W = dasp_pkg::FREQ_W;
	localparam int CNT_W  = dasp_pkg::CNT_W;
	localparam int PROD_W = dasp_pkg::PROD_W;
	localparam int QPROD_W = PROD_W + dasp_pkg::RECIP_W;

	// reload divider: BASE_TICK_HZ / (2 * rate), one bit per cycle
	localparam int NUM_W  = $clog2(BASE_TICK_HZ + 1);
	localparam int DEN_W  = FREQ_W + 1;
	localparam int STEP_W = $clog2(NUM_W + 1);
	localparam int QX_W   = (NUM_W > DIV_W) ? NUM_W : DIV_W;
	localparam logic [NUM_W-1:0] NUMER = NUM_W'(BASE_TICK_HZ);

	// ---------------- config registers ----------------
	logic [FREQ_W-1:0] step_freq_q;
	logic [CUR_W-1:0]  run_cur_q [2];
	logic [PCT_W-1:0]  hold_pct_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_freq_q  <= FREQ_W'(1000);
			run_cur_q[0] <= CUR_W'(20);
			run_cur_q[1] <= CUR_W'(20);
			hold_pct_q   <= PCT_W'(50);
		end else if (cfg_wr_en) begin
			case (dasp_pkg::cfg_idx_t'(cfg_index))
				dasp_pkg::CFG_STEP_FREQ: step_freq_q  <= cfg_wr_data;
				dasp_pkg::CFG_X_RUN:     run_cur_q[0] <= cfg_wr_data;
				dasp_pkg::CFG_Y_RUN:     run_cur_q[1] <= cfg_wr_data;
				dasp_pkg::CFG_HOLD_PCT:  hold_pct_q   <= cfg_wr_data[PCT_W-1:0];
				default: ;
			endcase
		end
	end

	// ---------------- hold current, two registered stages ----------------
	// settles well inside the divider pass that every config write starts
	logic [PROD_W-1:0] prod_s1 [2];
	logic [CUR_W-1:0]  hold_s2 [2];
	logic [QPROD_W-1:0] hold_quot [2];

	always_comb begin
		for (int k = 0; k < 2; k++) begin
			hold_quot[k] = QPROD_W'(prod_s1[k]) * QPROD_W'(dasp_pkg::HOLD_RECIP);
		end
	end

	always_ff @(posedge clk) begin
		for (int k = 0; k < 2; k++) begin
			prod_s1[k] <= PROD_W'(run_cur_q[k]) * PROD_W'(hold_pct_q);
			hold_s2[k] <= hold_quot[k][dasp_pkg::HOLD_SHIFT +: CUR_W];
		end
	end

	// ---------------- reload divider ----------------
	logic [FREQ_W-1:0] rate_clamped;
	logic              restart_q;
	logic              div_run_q;
	logic [STEP_W-1:0] div_step_q;
	logic [NUM_W-1:0]  num_q;
	logic [NUM_W-1:0]  quo_q;
	logic [DEN_W-1:0]  den_q;
	logic [DEN_W-1:0]  rem_q;
	logic [DEN_W:0]    rem_sh;
	logic              rem_ge;
	logic [NUM_W-1:0]  quo_next;
	logic [QX_W-1:0]   quo_ext;
	logic [DIV_W-1:0]  reload_next;
	logic [DIV_W-1:0]  reload_q;

	always_comb begin
		rate_clamped = step_freq_q;
		if (step_freq_q < FREQ_W'(STEP_MIN_HZ)) begin
			rate_clamped = FREQ_W'(STEP_MIN_HZ);
		end else if (step_freq_q > FREQ_W'(STEP_MAX_HZ)) begin
			rate_clamped = FREQ_W'(STEP_MAX_HZ);
		end
		if (rate_clamped == '0) begin
			rate_clamped = FREQ_W'(1);
		end

		rem_sh   = {rem_q, num_q[NUM_W-1]};
		rem_ge   = rem_sh >= (DEN_W+1)'(den_q);
		quo_next = {quo_q[NUM_W-2:0], rem_ge};
		quo_ext  = QX_W'(quo_next);
		// zero quotient saturates, wide quotient keeps its low bits
		reload_next = (quo_ext == '0) ? '0 : DIV_W'(quo_ext - QX_W'(1));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			restart_q  <= 1'b1;
			div_run_q  <= 1'b0;
			div_step_q <= '0;
			reload_q   <= '0;
		end else if (cfg_wr_en) begin
			restart_q <= 1'b1;
			div_run_q <= 1'b0;
		end else if (restart_q) begin
			restart_q  <= 1'b0;
			div_run_q  <= 1'b1;
			div_step_q <= STEP_W'(NUM_W);
		end else if (div_run_q) begin
			div_step_q <= div_step_q - STEP_W'(1);
			if (div_step_q == STEP_W'(1)) begin
				div_run_q <= 1'b0;
				reload_q  <= reload_next;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (restart_q) begin
			num_q <= NUMER;
			quo_q <= '0;
			rem_q <= '0;
			den_q <= {rate_clamped, 1'b0};
		end else if (div_run_q) begin
			num_q <= {num_q[NUM_W-2:0], 1'b0};
			quo_q <= quo_next;
			rem_q <= DEN_W'(rem_ge ? rem_sh - (DEN_W+1)'(den_q) : rem_sh);
		end
	end

	// ---------------- axis state ----------------
	logic [CNT_W-1:0] tog_q [2];
	logic [1:0]       run_q;
	logic [1:0]       dir_q;
	logic [1:0]       pin_q;
	logic [CUR_W-1:0] cmp_q [2];
	logic             tmr_q;
	logic [DIV_W-1:0] dcnt_q;

	logic [CNT_W-1:0] tog_d [2];
	logic [1:0]       run_d;
	logic [1:0]       dir_d;
	logic [1:0]       pin_d;
	logic [CUR_W-1:0] cmp_d [2];
	logic             tmr_d;
	logic [DIV_W-1:0] dcnt_d;

	dasp_pkg::mode_t  in_mode;
	logic [1:0]       in_axis;
	logic [31:0]      in_count;
	logic             count_neg;
	logic [CNT_W-1:0] count_mag;
	logic             in_accept;
	dasp_pkg::res_t   res_d;

	assign in_mode   = dasp_pkg::mode_t'(s_axis_tuser[2:0]);
	assign in_axis   = s_axis_tuser[4:3];
	assign in_count  = s_axis_tdata;
	assign count_neg = in_count[31];
	assign count_mag = count_neg ? (~in_count + 32'd1) : in_count;

	always_comb begin
		tog_d  = tog_q;
		run_d  = run_q;
		dir_d  = dir_q;
		pin_d  = pin_q;
		cmp_d  = cmp_q;
		tmr_d  = tmr_q;
		dcnt_d = dcnt_q;

		case (in_mode)
			dasp_pkg::MODE_TICK: begin
				if (tmr_q) begin
					if (dcnt_q >= reload_q) begin
						// update event
						dcnt_d = '0;
						for (int k = 0; k < 2; k++) begin
							if (run_q[k] && tog_q[k] != '0) begin
								pin_d[k] = ~pin_q[k];
								tog_d[k] = tog_q[k] - CNT_W'(1);
								if (tog_q[k] == CNT_W'(1)) begin
									run_d[k] = 1'b0;
								end
							end
						end
						if (run_d == 2'b00) begin
							tmr_d = 1'b0;
							pin_d = 2'b00;
						end
					end else begin
						dcnt_d = dcnt_q + DIV_W'(1);
					end
				end
			end
			dasp_pkg::MODE_MOVE: begin
				if (!in_axis[1] && in_count != '0) begin
					for (int k = 0; k < 2; k++) begin
						if (in_axis == 2'(k)) begin
							dir_d[k] = count_neg;
							tog_d[k] = count_mag;
							run_d[k] = 1'b1;
							cmp_d[k] = run_cur_q[k];
						end
					end
					dcnt_d = '0;
					tmr_d  = 1'b1;
				end
			end
			dasp_pkg::MODE_STOP_AXIS, dasp_pkg::MODE_STOP_ALL: begin
				for (int k = 0; k < 2; k++) begin
					if (in_mode == dasp_pkg::MODE_STOP_ALL || in_axis == 2'(k)) begin
						tog_d[k] = '0;
						run_d[k] = 1'b0;
						pin_d[k] = 1'b0;
					end
				end
				// a stop for a nonexistent axis leaves the timer alone
				if (run_d == 2'b00 && (in_mode == dasp_pkg::MODE_STOP_ALL || !in_axis[1])) begin
					tmr_d = 1'b0;
				end
			end
			dasp_pkg::MODE_HOLD: begin
				for (int k = 0; k < 2; k++) begin
					if (in_axis == 2'(k)) begin
						cmp_d[k] = hold_s2[k];
					end
				end
			end
			dasp_pkg::MODE_INIT: begin
				// reload already tracks step_freq_q; the tick count restarts and both axes go idle at run current
				dcnt_d = '0;
				for (int k = 0; k < 2; k++) begin
					tog_d[k] = '0;
					cmp_d[k] = run_cur_q[k];
				end
				run_d = 2'b00;
				dir_d = 2'b00;
				pin_d = 2'b00;
			end
			default: ;
		endcase

		res_d.x_step_level  = pin_d[0];
		res_d.y_step_level  = pin_d[1];
		res_d.x_direction   = dir_d[0];
		res_d.y_direction   = dir_d[1];
		res_d.timer_active  = tmr_d;
		res_d.x_remaining   = tog_d[0][CNT_W-1:1];
		res_d.y_remaining   = tog_d[1][CNT_W-1:1];
		res_d.x_current_ref = cmp_d[0];
		res_d.y_current_ref = cmp_d[1];
		res_d.x_idle        = (tog_d[0] == '0) && !run_d[0];
		res_d.y_idle        = (tog_d[1] == '0) && !run_d[1];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tog_q[0] <= '0;
			tog_q[1] <= '0;
			run_q    <= 2'b00;
			dir_q    <= 2'b00;
			pin_q    <= 2'b00;
			cmp_q[0] <= '0;
			cmp_q[1] <= '0;
			tmr_q    <= 1'b0;
			dcnt_q   <= '0;
		end else begin
			if (cfg_wr_en && dasp_pkg::cfg_idx_t'(cfg_index) == dasp_pkg::CFG_STEP_FREQ) begin
				dcnt_q <= '0;
			end else if (in_accept) begin
				dcnt_q <= dcnt_d;
			end
			if (in_accept) begin
				tog_q <= tog_d;
				run_q <= run_d;
				dir_q <= dir_d;
				pin_q <= pin_d;
				cmp_q <= cmp_d;
				tmr_q <= tmr_d;
			end
		end
	end

	// ---------------- output register and skid ----------------
	logic           out_valid_q;
	logic           skid_valid_q;
	dasp_pkg::res_t out_q;
	dasp_pkg::res_t skid_q;
	logic           out_take;

	assign s_axis_tready = !restart_q && !div_run_q && !skid_valid_q;
	assign in_accept     = s_axis_tvalid && s_axis_tready;
	assign out_take      = out_valid_q && m_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (out_take) begin
			if (skid_valid_q) begin
				skid_valid_q <= 1'b0;
			end else begin
				out_valid_q <= in_accept;
			end
		end else if (in_accept) begin
			if (out_valid_q) begin
				skid_valid_q <= 1'b1;
			end else begin
				out_valid_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (out_take && skid_valid_q) begin
			out_q <= skid_q;
		end else if (in_accept && (out_take || !out_valid_q)) begin
			out_q <= res_d;
		end else if (in_accept) begin
			skid_q <= res_d;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = dasp_pkg::M_TDATA_W'(out_q);

endmodule

`default_nettype wire
